[hw/rtl/bqs_pkg.sv]
// shared types, widths and constants of the smoothed biquad
`default_nettype none

package bqs_pkg;

  // field widths and fixed point formats
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int COEF_FRAC   = COEF_BITS - 5;
  localparam int RAW_BITS    = 32;
  localparam int KEEP_BITS   = 16;
  localparam int NUM_COEF    = 5;
  localparam int LANE_W      = 3;

  // quotient: integer bits of raw/a0 before saturation, and bits produced per lane
  localparam int QI_BITS    = COEF_BITS - 1 - COEF_FRAC;
  localparam int DIV_STEPS  = QI_BITS + COEF_FRAC + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int DIV_REM_W  = RAW_BITS - 1;
  localparam int DIV_CMP_W  = RAW_BITS - 1 + QI_BITS;

  // shared multiplier: coefficient or coefficient step times sample or keep complement
  localparam int MUL_A_W = COEF_BITS + 1;
  localparam int MUL_B_W = (SAMPLE_BITS > KEEP_BITS + 1) ? SAMPLE_BITS : KEEP_BITS + 2;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int RND_W   = MUL_P_W - COEF_FRAC;
  localparam int ACC_W   = COEF_BITS + 2;
  localparam int GLIDE_W = COEF_BITS + KEEP_BITS + 2;

  // constants
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
  localparam logic [COEF_BITS-1:0] COEF_MAX_U = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [MUL_P_W-1:0] RND_HALF    = MUL_P_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [MUL_P_W-1:0] RND_HALF_M1 = RND_HALF - MUL_P_W'(1);
  localparam logic signed [GLIDE_W-1:0] GLIDE_HALF  = GLIDE_W'(1) << (KEEP_BITS - 1);
  localparam logic [KEEP_BITS:0] KEEP_ONE = {1'b1, {KEEP_BITS{1'b0}}};
  localparam logic [KEEP_BITS:0] KEEP_COMP_RESET = KEEP_ONE - (KEEP_BITS+1)'(65470);

  // saturation limits in accumulator width
  localparam logic signed [ACC_W-1:0] Y_MAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [ACC_W-1:0] D_MAX =
    ACC_W'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] D_MIN = ACC_W'(-(64'sd1 <<< (COEF_BITS - 1)));

  // coefficient slots
  localparam logic [LANE_W-1:0] CI_B0 = 3'd0;
  localparam logic [LANE_W-1:0] CI_B1 = 3'd1;
  localparam logic [LANE_W-1:0] CI_B2 = 3'd2;
  localparam logic [LANE_W-1:0] CI_A1 = 3'd3;
  localparam logic [LANE_W-1:0] CI_A2 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_F_MUL,
    ST_F_RND,
    ST_F_ACC,
    ST_DIV,
    ST_QFIN,
    ST_DIFF,
    ST_G_MUL,
    ST_G_ADD,
    ST_DONE
  } bqs_state_t;

  // filter product steps, in evaluation order
  typedef enum logic [2:0] {
    FS_B0X,
    FS_B1X,
    FS_A1Y,
    FS_B2X,
    FS_A2Y
  } bqs_fstep_t;

  typedef struct packed {
    logic             load;
    logic             div_init;
    logic             div_step;
    logic             q_fin;
    logic             diff_load;
    logic             mul_glide;
    logic             use_y;
    logic             f_rnd;
    logic             f_acc;
    logic             g_add;
    logic             out_load;
    bqs_fstep_t       step;
    logic [LANE_W-1:0] lane;
  } bqs_cmd_t;

  typedef struct packed {
    logic mode;
    logic bad;
  } bqs_stat_t;

  // coefficient used by each filter step
  function automatic logic [LANE_W-1:0] step_coef(input bqs_fstep_t s);
    logic [LANE_W-1:0] c;
    case (s)
      FS_B0X:  c = CI_B0;
      FS_B1X:  c = CI_B1;
      FS_A1Y:  c = CI_A1;
      FS_B2X:  c = CI_B2;
      FS_A2Y:  c = CI_A2;
      default: c = CI_B0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bqs_if.sv]
// valid/ready channel interfaces for requests and results
`default_nettype none

interface bqs_in_if import bqs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [RAW_BITS-1:0]    raw_b0;
  logic signed [RAW_BITS-1:0]    raw_b1;
  logic signed [RAW_BITS-1:0]    raw_b2;
  logic signed [RAW_BITS-1:0]    raw_a0;
  logic signed [RAW_BITS-1:0]    raw_a1;
  logic signed [RAW_BITS-1:0]    raw_a2;

  modport source (
    output valid, mode, sample_in, raw_b0, raw_b1, raw_b2, raw_a0, raw_a1, raw_a2,
    input  ready
  );
  modport sink (
    input  valid, mode, sample_in, raw_b0, raw_b1, raw_b2, raw_a0, raw_a1, raw_a2,
    output ready
  );
endinterface

interface bqs_out_if import bqs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;
  logic                          bad_divisor;

  modport source (
    output valid, sample_out, clipped, bad_divisor,
    input  ready
  );
  modport sink (
    input  valid, sample_out, clipped, bad_divisor,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/bqs_ctrl.sv]
// sequencer for filter steps, coefficient division and glide updates
`default_nettype none

module bqs_ctrl import bqs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bqs_stat_t stat,
  output bqs_cmd_t  cmd
);

  bqs_state_t           state, state_next;
  bqs_fstep_t           step, step_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic [LANE_W-1:0]    gl_lane, gl_lane_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= FS_B0X;
      div_cnt   <= '0;
      gl_lane   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      div_cnt   <= div_cnt_next;
      gl_lane   <= gl_lane_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and counters
  always_comb begin
    state_next   = state;
    step_next    = step;
    div_cnt_next = div_cnt;
    gl_lane_next = gl_lane;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        step_next    = FS_B0X;
        div_cnt_next = '0;
        gl_lane_next = '0;
        if (!stat.mode) begin
          state_next = ST_F_MUL;
        end else if (stat.bad) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_F_MUL: state_next = ST_F_RND;
      ST_F_RND: state_next = ST_F_ACC;
      ST_F_ACC: begin
        state_next = ST_F_MUL;
        case (step)
          FS_B0X:  step_next = FS_B1X;
          FS_B1X:  step_next = FS_A1Y;
          FS_A1Y:  step_next = FS_B2X;
          FS_B2X:  step_next = FS_A2Y;
          FS_A2Y:  state_next = ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_DIV: begin
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_QFIN;
        end
      end
      ST_QFIN: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_G_MUL;
      ST_G_MUL: state_next = ST_G_ADD;
      ST_G_ADD: begin
        if (gl_lane == LANE_W'(NUM_COEF - 1)) begin
          state_next = ST_DONE;
        end else begin
          gl_lane_next = gl_lane + LANE_W'(1);
          state_next   = ST_G_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd            = '0;
    cmd.step       = step;
    cmd.lane       = gl_lane;
    cmd.use_y      = (step == FS_A1Y) || (step == FS_A2Y);
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: cmd.div_init = stat.mode && !stat.bad;
      ST_F_MUL: cmd.lane = step_coef(step);
      ST_F_RND: cmd.f_rnd = 1'b1;
      ST_F_ACC: cmd.f_acc = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_QFIN:  cmd.q_fin = 1'b1;
      ST_DIFF:  cmd.diff_load = 1'b1;
      ST_G_MUL: cmd.mul_glide = 1'b1;
      ST_G_ADD: cmd.g_add = 1'b1;
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/bqs_datapath.sv]
// registers, shared multiplier, division lanes and saturation of the biquad
`default_nettype none

module bqs_datapath import bqs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  bqs_cmd_t                      cmd,
  output bqs_stat_t                     stat,
  input  logic                          cfg_write,
  input  logic [KEEP_BITS-1:0]          cfg_data,
  input  logic                          mode,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [RAW_BITS-1:0]    raw_b0,
  input  logic signed [RAW_BITS-1:0]    raw_b1,
  input  logic signed [RAW_BITS-1:0]    raw_b2,
  input  logic signed [RAW_BITS-1:0]    raw_a0,
  input  logic signed [RAW_BITS-1:0]    raw_a1,
  input  logic signed [RAW_BITS-1:0]    raw_a2,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped,
  output logic                          bad_divisor
);

  // configuration and model state
  logic [KEEP_BITS:0]            keep_comp;
  logic signed [COEF_BITS-1:0]   coef [NUM_COEF];
  logic signed [COEF_BITS-1:0]   d1, d2;

  // latched transaction
  logic                          mode_r, bad_r;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [RAW_BITS-2:0]           ud;
  logic                          neg [NUM_COEF];
  logic [RAW_BITS-1:0]           raw_mag_r [NUM_COEF];

  // filter working registers
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          clip;
  logic signed [ACC_W-1:0]       acc;
  logic signed [RND_W-1:0]       rnd;
  logic signed [MUL_P_W-1:0]     mul_p;

  // division lanes
  logic [DIV_REM_W-1:0]          rem [NUM_COEF];
  logic [RAW_BITS-1:0]           dsh [NUM_COEF];
  logic [COEF_BITS-1:0]          quo [NUM_COEF];
  logic                          ovf [NUM_COEF];
  logic signed [COEF_BITS-1:0]   target [NUM_COEF];
  logic signed [COEF_BITS:0]     diff [NUM_COEF];

  // combinational
  logic signed [MUL_A_W-1:0]     op_a;
  logic signed [MUL_B_W-1:0]     op_b;
  logic signed [MUL_P_W-1:0]     rnd_sum;
  logic signed [ACC_W-1:0]       acc_base, acc_sum;
  logic                          acc_sub;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [COEF_BITS-1:0]   d_sat;
  logic                          y_clip, d_clip;
  logic signed [GLIDE_W-1:0]     glide_sum;
  logic [RAW_BITS-1:0]           raw_in [NUM_COEF];
  logic [RAW_BITS-1:0]           mag_in [NUM_COEF];
  logic [DIV_REM_W:0]            div_t [NUM_COEF];
  logic                          div_ge [NUM_COEF];
  logic [COEF_BITS:0]            q_inc [NUM_COEF];
  logic [COEF_BITS-1:0]          q_half [NUM_COEF];
  logic [COEF_BITS-1:0]          q_mag [NUM_COEF];

  assign stat.mode = mode_r;
  assign stat.bad  = bad_r;

  assign raw_in[CI_B0] = raw_b0;
  assign raw_in[CI_B1] = raw_b1;
  assign raw_in[CI_B2] = raw_b2;
  assign raw_in[CI_A1] = raw_a1;
  assign raw_in[CI_A2] = raw_a2;

  // multiplier operand select
  always_comb begin
    if (cmd.mul_glide) begin
      op_a = MUL_A_W'(diff[cmd.lane]);
      op_b = MUL_B_W'({1'b0, keep_comp});
    end else begin
      op_a = MUL_A_W'(coef[cmd.lane]);
      op_b = cmd.use_y ? MUL_B_W'(y) : MUL_B_W'(x);
    end
  end

  // product rounding to sample lsb, ties away from zero
  assign rnd_sum = mul_p + (mul_p[MUL_P_W-1] ? RND_HALF_M1 : RND_HALF);

  // accumulate and saturate per filter step
  always_comb begin
    case (cmd.step)
      FS_B0X: begin
        acc_base = ACC_W'(d1);
        acc_sub  = 1'b0;
      end
      FS_B1X: begin
        acc_base = ACC_W'(d2);
        acc_sub  = 1'b0;
      end
      FS_A1Y: begin
        acc_base = acc;
        acc_sub  = 1'b1;
      end
      FS_B2X: begin
        acc_base = '0;
        acc_sub  = 1'b0;
      end
      FS_A2Y: begin
        acc_base = acc;
        acc_sub  = 1'b1;
      end
      default: begin
        acc_base = '0;
        acc_sub  = 1'b0;
      end
    endcase
    acc_sum = acc_sub ? acc_base - ACC_W'(rnd) : acc_base + ACC_W'(rnd);

    y_clip = (acc_sum > Y_MAX) || (acc_sum < Y_MIN);
    if (acc_sum > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (acc_sum < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = acc_sum[SAMPLE_BITS-1:0];
    end

    d_clip = (acc_sum > D_MAX) || (acc_sum < D_MIN);
    if (acc_sum > D_MAX) begin
      d_sat = D_MAX[COEF_BITS-1:0];
    end else if (acc_sum < D_MIN) begin
      d_sat = D_MIN[COEF_BITS-1:0];
    end else begin
      d_sat = acc_sum[COEF_BITS-1:0];
    end
  end

  // division lane logic
  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      mag_in[i] = raw_mag_r[i];
      div_t[i]  = {rem[i], dsh[i][RAW_BITS-1]};
      div_ge[i] = div_t[i] >= {1'b0, ud};
      q_inc[i]  = {1'b0, quo[i]} + (COEF_BITS+1)'(1);
      q_half[i] = q_inc[i][COEF_BITS:1];
      q_mag[i]  = (ovf[i] || (q_half[i] > COEF_MAX_U)) ? COEF_MAX_U : q_half[i];
    end
  end

  // glide: old + (1 - keep) * (target - old), rounded half up
  assign glide_sum = (GLIDE_W'(coef[cmd.lane]) <<< KEEP_BITS) + GLIDE_W'(mul_p) + GLIDE_HALF;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_comp <= KEEP_COMP_RESET;
    end else if (cfg_write) begin
      keep_comp <= KEEP_ONE - {1'b0, cfg_data};
    end
  end

  // coefficients and delay states
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef[i] <= (i == int'(CI_B0)) ? COEF_ONE : '0;
      end
      d1 <= '0;
      d2 <= '0;
    end else begin
      if (cmd.g_add) begin
        coef[cmd.lane] <= glide_sum[KEEP_BITS +: COEF_BITS];
      end
      if (cmd.f_acc && (cmd.step == FS_A1Y)) begin
        d1 <= d_sat;
      end
      if (cmd.f_acc && (cmd.step == FS_A2Y)) begin
        d2 <= d_sat;
      end
    end
  end

  // transaction capture, filter datapath and division lanes
  always_ff @(posedge clk) begin
    mul_p <= op_a * op_b;
    if (cmd.load) begin
      mode_r <= mode;
      bad_r  <= raw_a0[RAW_BITS-1] || (raw_a0 == '0);
      x      <= sample_in;
      ud     <= raw_a0[RAW_BITS-2:0];
      clip   <= 1'b0;
      for (int i = 0; i < NUM_COEF; i++) begin
        neg[i]       <= raw_in[i][RAW_BITS-1];
        raw_mag_r[i] <= raw_in[i][RAW_BITS-1] ? RAW_BITS'(-raw_in[i]) : raw_in[i];
      end
    end
    if (cmd.f_rnd) begin
      rnd <= rnd_sum[COEF_FRAC +: RND_W];
    end
    if (cmd.f_acc) begin
      case (cmd.step)
        FS_B0X: begin
          y    <= y_sat;
          clip <= clip | y_clip;
        end
        FS_B1X:  acc <= acc_sum;
        FS_A1Y:  clip <= clip | d_clip;
        FS_B2X:  acc <= acc_sum;
        FS_A2Y:  clip <= clip | d_clip;
        default: acc <= acc_sum;
      endcase
    end
    for (int i = 0; i < NUM_COEF; i++) begin
      if (cmd.div_init) begin
        ovf[i] <= DIV_CMP_W'(mag_in[i]) >= (DIV_CMP_W'(ud) << QI_BITS);
        rem[i] <= DIV_REM_W'(mag_in[i] >> QI_BITS);
        dsh[i] <= mag_in[i] << (RAW_BITS - QI_BITS);
        quo[i] <= '0;
      end else if (cmd.div_step) begin
        rem[i] <= div_ge[i] ? DIV_REM_W'(div_t[i] - {1'b0, ud}) : div_t[i][DIV_REM_W-1:0];
        dsh[i] <= dsh[i] << 1;
        quo[i] <= {quo[i][COEF_BITS-2:0], div_ge[i]};
      end
      if (cmd.q_fin) begin
        target[i] <= neg[i] ? COEF_BITS'(-q_mag[i]) : q_mag[i];
      end
      if (cmd.diff_load) begin
        diff[i] <= (COEF_BITS+1)'(target[i]) - (COEF_BITS+1)'(coef[i]);
      end
    end
    if (cmd.out_load) begin
      sample_out  <= mode_r ? '0 : y;
      clipped     <= mode_r ? 1'b0 : clip;
      bad_divisor <= mode_r & bad_r;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/biquad_with_coefficient_smoothing_unit.sv]
// top level of the biquad with gliding coefficients
//
//   channel  | dir | handshake   | carries
//   req      | in  | valid/ready | mode, sample_in, raw_b0..raw_a2
//   rsp      | out | valid/ready | sample_out, clipped, bad_divisor
//   cfg      | in  | write only  | smooth_keep on cfg_data when cfg_write
//
// a filter transaction runs five products through one shared multiplier,
// each multiply, round and accumulate in turn.
// a coefficient update is set by the 32 step restoring division
// that runs in five parallel lanes, then five glide multiplies; a bad divisor skips both.
// synchronous reset loads the default coefficients and delays.
// results wait in the output register; a finished transaction holds until it is free.
`default_nettype none

module biquad_with_coefficient_smoothing_unit import bqs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bqs_in_if.sink               req,
  bqs_out_if.source            rsp,
  input  logic                 cfg_write,
  input  logic [KEEP_BITS-1:0] cfg_data
);

  bqs_cmd_t  cmd;
  bqs_stat_t stat;

  // sequencer
  bqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and state
  bqs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mode        (req.mode),
    .sample_in   (req.sample_in),
    .raw_b0      (req.raw_b0),
    .raw_b1      (req.raw_b1),
    .raw_b2      (req.raw_b2),
    .raw_a0      (req.raw_a0),
    .raw_a1      (req.raw_a1),
    .raw_a2      (req.raw_a2),
    .sample_out  (rsp.sample_out),
    .clipped     (rsp.clipped),
    .bad_divisor (rsp.bad_divisor)
  );

endmodule

`default_nettype wire
